// ----- rtl/pidpd_pkg.sv -----
// Types, constants and a helper function shared by the power-to-DAC converter.
package pidpd_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int SCALE_BITS = 12;
  localparam int CODE_SHIFT = FRAC_BITS + SCALE_BITS;
  localparam int DAC_MAX    = 4095;
  localparam logic signed [25:0] VOLTAGE_OFFSET = 26'sd0;

  localparam int SQRT_STEPS = 24;
  localparam int DIV_STEPS  = 24;

  localparam logic [1:0] ROUTE_CURRENT = 2'd1;
  localparam logic [1:0] ROUTE_VOLTAGE = 2'd2;

  localparam logic [1:0] TGT_NONE    = 2'd0;
  localparam logic [1:0] TGT_CURRENT = 2'd1;
  localparam logic [1:0] TGT_VOLTAGE = 2'd2;

  typedef struct packed {
    logic               loop_index;
    logic signed [31:0] power_demand;
    logic [23:0]        mosfet_voltage;
    logic [23:0]        mosfet_current;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  dac_target;
    logic [11:0] dac_code;
    logic        power_limited;
    logic        low_current_pin;
  } out_item_t;

  typedef enum logic [2:0] {
    CFG_MAX_POWER_LOSS,
    CFG_CURRENT_OFFSET,
    CFG_MAX_CURRENT,
    CFG_CURRENT_DAC_SCALE,
    CFG_MAX_VOLTAGE,
    CFG_VOLTAGE_DAC_SCALE,
    CFG_CUR_TO_VOLT_SCALE,
    CFG_ROUTE_SELECT
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MUL_POWER,
    MUL_VOLT,
    MUL_CODE_CUR,
    MUL_CODE_VOLT
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQRT,
    ST_ROUTE,
    ST_PMUL,
    ST_PCMP,
    ST_DIV,
    ST_DFIN,
    ST_CSUM,
    ST_CMUL,
    ST_VMUL,
    ST_VCHK,
    ST_VCMUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic     load;
    logic     sqrt_step;
    logic     cur_from_root;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_init;
    logic     div_step;
    logic     cur_from_quot;
    logic     cur_sum;
    logic     volt_sum;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] route;
    logic       p_over;
    logic       out_free;
  } sts_t;

  // Round half up from Q.(F+12) to an integer code, saturate to 0..DAC_MAX.
  function automatic logic [11:0] to_code(input logic signed [50:0] v);
    logic [51:0] s;
    logic [11:0] code;
    s = {1'b0, v} + (52'd1 << (CODE_SHIFT - 1));
    if (v <= 0) begin
      code = 12'd0;
    end else if (s[51:CODE_SHIFT] > 24'(DAC_MAX)) begin
      code = 12'(DAC_MAX);
    end else begin
      code = s[CODE_SHIFT+11:CODE_SHIFT];
    end
    return code;
  endfunction

endpackage

// ----- rtl/pid_power_to_dac_output.sv -----
// Top level of the PID power demand to DAC code converter.
// Each item runs the square root and the route pick; the voltage route adds a scale,
// limit check and code multiply, the current route a power check, an optional divide,
// current sum and code multiply. The input stalls until the item's result is registered.
// The output register frees the input side while a result waits.
// Synchronous active-low reset: config registers cleared to zero, pin low, no result pending.
module pid_power_to_dac_output (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pidpd_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pidpd_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_wdata
);
  import pidpd_pkg::*;

  cmd_t cmd;  // sequencer to datapath
  sts_t sts;  // datapath flags back to sequencer

  // sequencer: root, route pick, power check and optional divide or voltage scale, code multiply
  pidpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath holds the config, the pin level and the result register
  pidpd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- rtl/pidpd_ctrl.sv -----
// Sequencer for the power-to-DAC converter: steps the datapath through one item.
module pidpd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  pidpd_pkg::sts_t sts,
  output pidpd_pkg::cmd_t cmd
);
  import pidpd_pkg::*;

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 5'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.mul_sel = MUL_POWER;
    in_stall    = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = 5'd0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 5'd1;
        if (cnt_r == 5'(SQRT_STEPS - 1)) state_nxt = ST_ROUTE;
      end
      ST_ROUTE: begin
        cmd.cur_from_root = 1'b1;
        if (sts.route == ROUTE_CURRENT)      state_nxt = ST_PMUL;
        else if (sts.route == ROUTE_VOLTAGE) state_nxt = ST_VMUL;
        else                                 state_nxt = ST_FIN;
      end
      ST_PMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_POWER;
        state_nxt   = ST_PCMP;
      end
      ST_PCMP: begin
        if (sts.p_over) begin
          cmd.div_init = 1'b1;
          cnt_nxt      = 5'd0;
          state_nxt    = ST_DIV;
        end else begin
          state_nxt = ST_CSUM;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_STEPS - 1)) state_nxt = ST_DFIN;
      end
      ST_DFIN: begin
        cmd.cur_from_quot = 1'b1;
        state_nxt         = ST_CSUM;
      end
      ST_CSUM: begin
        cmd.cur_sum = 1'b1;
        state_nxt   = ST_CMUL;
      end
      ST_CMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CODE_CUR;
        state_nxt   = ST_FIN;
      end
      ST_VMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_VOLT;
        state_nxt   = ST_VCHK;
      end
      ST_VCHK: begin
        cmd.volt_sum = 1'b1;
        state_nxt    = ST_VCMUL;
      end
      ST_VCMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CODE_VOLT;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/pidpd_datapath.sv -----
// Datapath: config registers, bit-pair square root, restoring divider, shared multiplier.
module pidpd_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  pidpd_pkg::in_item_t  in_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output pidpd_pkg::out_item_t out_data,
  input  pidpd_pkg::cmd_t      cmd,
  output pidpd_pkg::sts_t      sts
);
  import pidpd_pkg::*;

  // configuration
  logic [31:0]        max_power_r;
  logic signed [24:0] cur_offset_r;
  logic [23:0]        max_current_r, cur_scale_r, max_voltage_r, volt_scale_r, c2v_scale_r;
  logic [3:0]         route_sel_r;

  logic      pin_r, out_valid_r;
  out_item_t out_r;

  // item and working registers
  logic               loop_r;
  logic [23:0]        vm_r, im_r;
  logic [47:0]        rad_r;
  logic [25:0]        rem_r;
  logic [23:0]        root_r, cur_r, drem_r, dq_r;
  logic signed [50:0] prod_r;
  logic signed [25:0] sum_r;
  logic               limited_r, zero_r, pin_new_r;

  logic [1:0]         route;
  logic [47:0]        plimit;
  logic [25:0]        s_rem, s_trial;
  logic               s_ge;
  logic [24:0]        d_t;
  logic               d_ge;
  logic signed [25:0] mul_a;
  logic [23:0]        mul_b;
  logic signed [24:0] mul_bs;
  logic signed [25:0] off26, cur26, max26;
  logic [24:0]        offmag;
  logic [31:0]        volt;
  logic [30:0]        dem_pos;
  logic [11:0]        code;
  logic [1:0]         target;

  assign route   = loop_r ? route_sel_r[3:2] : route_sel_r[1:0];
  assign plimit  = 48'(max_power_r) << FRAC_BITS;
  assign dem_pos = in_data.power_demand[31] ? 31'd0 : in_data.power_demand[30:0];

  assign s_rem   = {rem_r[23:0], rad_r[47:46]};
  assign s_trial = {root_r, 2'b01};
  assign s_ge    = s_rem >= s_trial;

  assign d_t  = {drem_r, dq_r[23]};
  assign d_ge = d_t >= {1'b0, vm_r};

  assign off26  = 26'(cur_offset_r);
  assign cur26  = $signed({2'b00, cur_r});
  assign max26  = $signed({2'b00, max_current_r});
  assign offmag = cur_offset_r[24] ? 25'(-cur_offset_r) : 25'(cur_offset_r);
  assign volt   = prod_r[FRAC_BITS+31:FRAC_BITS];

  always_comb begin
    case (cmd.mul_sel)
      MUL_POWER: begin
        mul_a = $signed({2'b00, vm_r});
        mul_b = im_r;
      end
      MUL_VOLT: begin
        mul_a = cur26;
        mul_b = c2v_scale_r;
      end
      MUL_CODE_CUR: begin
        mul_a = sum_r;
        mul_b = cur_scale_r;
      end
      default: begin
        mul_a = sum_r;
        mul_b = volt_scale_r;
      end
    endcase
  end
  assign mul_bs = $signed({1'b0, mul_b});

  always_comb begin
    if (route == ROUTE_CURRENT)      target = TGT_CURRENT;
    else if (route == ROUTE_VOLTAGE) target = TGT_VOLTAGE;
    else                             target = TGT_NONE;
    code = (target == TGT_NONE || zero_r) ? 12'd0 : to_code(prod_r);
  end

  assign sts.route    = route;
  assign sts.p_over   = prod_r[47:0] > plimit;
  assign sts.out_free = !out_valid_r || !out_stall;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_power_r   <= '0;
      cur_offset_r  <= '0;
      max_current_r <= '0;
      cur_scale_r   <= '0;
      max_voltage_r <= '0;
      volt_scale_r  <= '0;
      c2v_scale_r   <= '0;
      route_sel_r   <= '0;
      pin_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_MAX_POWER_LOSS:    max_power_r   <= cfg_wdata;
          CFG_CURRENT_OFFSET:    cur_offset_r  <= $signed(cfg_wdata[24:0]);
          CFG_MAX_CURRENT:       max_current_r <= cfg_wdata[23:0];
          CFG_CURRENT_DAC_SCALE: cur_scale_r   <= cfg_wdata[23:0];
          CFG_MAX_VOLTAGE:       max_voltage_r <= cfg_wdata[23:0];
          CFG_VOLTAGE_DAC_SCALE: volt_scale_r  <= cfg_wdata[23:0];
          CFG_CUR_TO_VOLT_SCALE: c2v_scale_r   <= cfg_wdata[23:0];
          CFG_ROUTE_SELECT:      route_sel_r   <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        if (target == TGT_CURRENT) pin_r <= pin_new_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      loop_r    <= in_data.loop_index;
      vm_r      <= in_data.mosfet_voltage;
      im_r      <= in_data.mosfet_current;
      rad_r     <= 48'(dem_pos) << FRAC_BITS;
      rem_r     <= '0;
      root_r    <= '0;
      limited_r <= 1'b0;
      zero_r    <= 1'b0;
      pin_new_r <= 1'b0;
    end
    if (cmd.sqrt_step) begin
      rad_r  <= {rad_r[45:0], 2'b00};
      rem_r  <= s_ge ? s_rem - s_trial : s_rem;
      root_r <= {root_r[22:0], s_ge};
    end
    if (cmd.cur_from_root) cur_r <= root_r;
    if (cmd.mul_en) prod_r <= mul_a * mul_bs;
    if (cmd.div_init) begin
      drem_r    <= plimit[47:24];
      dq_r      <= plimit[23:0];
      limited_r <= 1'b1;
    end
    if (cmd.div_step) begin
      drem_r <= d_ge ? 24'(d_t - {1'b0, vm_r}) : d_t[23:0];
      dq_r   <= {dq_r[22:0], d_ge};
    end
    if (cmd.cur_from_quot) cur_r <= dq_r;
    if (cmd.cur_sum) begin
      if ({1'b0, cur_r} > {1'b0, max_current_r}) begin
        sum_r     <= off26 + max26;
        pin_new_r <= 1'b0;
        zero_r    <= 1'b0;
      end else if ({1'b0, cur_r} >= offmag) begin
        sum_r     <= off26 + cur26;
        pin_new_r <= 1'b0;
        zero_r    <= 1'b0;
      end else begin
        sum_r     <= '0;
        pin_new_r <= 1'b1;
        zero_r    <= 1'b1;
      end
    end
    if (cmd.volt_sum) begin
      zero_r <= volt > {8'd0, max_voltage_r};
      sum_r  <= VOLTAGE_OFFSET + $signed({2'b00, volt[23:0]});
    end
    if (cmd.finish) begin
      out_r.dac_target      <= target;
      out_r.dac_code        <= code;
      out_r.power_limited   <= (target == TGT_CURRENT) && limited_r;
      out_r.low_current_pin <= (target == TGT_CURRENT) ? pin_new_r : pin_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/pidpd_checker.sv -----
// Port-level assertions for the converter and the bind that attaches them.
module pidpd_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input pidpd_pkg::out_item_t out_data
);
  import pidpd_pkg::*;

  a_target_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.dac_target == TGT_NONE || out_data.dac_target == TGT_CURRENT ||
                   out_data.dac_target == TGT_VOLTAGE))
    else $error("illegal dac_target");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.dac_target == TGT_NONE) |-> (out_data.dac_code == 12'd0 &&
                                                        !out_data.power_limited))
    else $error("no-write result carries data");

  a_limit_current: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.power_limited) |-> out_data.dac_target == TGT_CURRENT)
    else $error("power limit off the current route");

  a_low_pin_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.dac_target == TGT_CURRENT && out_data.low_current_pin)
      |-> out_data.dac_code == 12'd0)
    else $error("low-current pin with nonzero code");

  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while busy");

endmodule

bind pid_power_to_dac_output pidpd_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_data  (out_data)
);
